@@ rtl/k_way_merge_assert.svh @@
// Assertion macros shared by the k_way_merge checkers.
`ifndef K_WAY_MERGE_ASSERT_SVH
`define K_WAY_MERGE_ASSERT_SVH

// Same-cycle implication, sampled on aclk, quiet while aresetn is low.
`define KWM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("k_way_merge: port check failed");

// Next-cycle implication, sampled on aclk, quiet while aresetn is low.
`define KWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("k_way_merge: port check failed");

`endif

@@ rtl/kwm_pkg.sv @@
// Shared types and constants of the k-way merge block.
`timescale 1ns / 1ps

package kwm_pkg;

    localparam int DATA_W     = 32;
    localparam int LANE_W     = 2;
    localparam int CFG_W      = 3;
    localparam int RESULT_CAP = 64;
    localparam logic [CFG_W-1:0] ACT_RESET = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic push;
        logic scan_start;
        logic scan_issue;
        logic pop;
        logic emit_status;
    } kwm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pending;
        logic scan_last;
        logic out_free;
        logic last_pop;
        logic finish_needed;
    } kwm_status_t;

endpackage

@@ rtl/kwm_ctrl.sv @@
// Controller state machine of the k-way merge block.
`timescale 1ns / 1ps

module kwm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  kwm_pkg::kwm_status_t status,
    output kwm_pkg::kwm_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_POP    = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.push   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.pending) begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_POP;
            end
            ST_POP: begin
                if (status.out_free) begin
                    cmd.pop    = 1'b1;
                    state_next = status.last_pop ? ST_IDLE : ST_CHECK;
                end
            end
            ST_FINISH: begin
                if (!status.finish_needed) begin
                    state_next = ST_IDLE;
                end else if (status.out_free) begin
                    cmd.emit_status = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/kwm_datapath.sv @@
// Datapath of the k-way merge block: lane queues, head scan and output register.
`timescale 1ns / 1ps

module kwm_datapath #(
    parameter int LANES      = 4,
    parameter int LANE_DEPTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  kwm_pkg::kwm_cmd_t                    cmd,
    output kwm_pkg::kwm_status_t                 status,
    input  logic [kwm_pkg::LANE_W-1:0]           s_lane,
    input  logic signed [kwm_pkg::DATA_W-1:0]    s_value,
    input  logic                                 s_has_value,
    input  logic                                 s_lane_done,
    input  logic                                 cfg_valid,
    input  logic [kwm_pkg::CFG_W-1:0]            cfg_active_lanes,
    input  logic                                 m_ready,
    output logic                                 m_valid,
    output logic signed [kwm_pkg::DATA_W-1:0]    m_merged_value,
    output logic                                 m_valid_res,
    output logic                                 m_last,
    output logic                                 m_error
);

    localparam int PTR_W     = $clog2(LANE_DEPTH);
    localparam int CNT_W     = $clog2(LANE_DEPTH + 1);
    localparam int SCAN_W    = $clog2(LANES);
    localparam int ACT_W     = $clog2(LANES + 1);
    localparam int MEM_DEPTH = LANES * LANE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int N_W       = $clog2(kwm_pkg::RESULT_CAP + 1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(LANE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic [kwm_pkg::CFG_W-1:0] act_cfg_reg;
    logic [ACT_W-1:0]          eff_act;

    logic [PTR_W-1:0] rd_ptr_reg [LANES];
    logic [PTR_W-1:0] rd_ptr_next [LANES];
    logic [PTR_W-1:0] wr_ptr_reg [LANES];
    logic [PTR_W-1:0] wr_ptr_next [LANES];
    logic [CNT_W-1:0] count_reg [LANES];
    logic [CNT_W-1:0] count_next [LANES];
    logic [LANES-1:0] finished_reg;
    logic [LANES-1:0] finished_next;

    logic [kwm_pkg::DATA_W-1:0] mem [MEM_DEPTH];
    logic signed [kwm_pkg::DATA_W-1:0] rdata_reg;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;

    logic [SCAN_W-1:0] issue_idx_reg;
    logic [SCAN_W-1:0] cmp_idx_reg;
    logic              cmp_valid_reg;
    logic [SCAN_W-1:0] best_idx_reg;
    logic signed [kwm_pkg::DATA_W-1:0] best_val_reg;
    logic              best_any_reg;

    logic           err_reg;
    logic [N_W-1:0] n_reg;

    logic                              m_valid_reg;
    logic signed [kwm_pkg::DATA_W-1:0] m_value_reg;
    logic                              m_valid_res_reg;
    logic                              m_last_reg;
    logic                              m_error_reg;

    logic [LANES-1:0] active_vec;
    logic [LANES-1:0] nonempty_vec;
    logic [LANES-1:0] full_vec;
    logic [LANES-1:0] in_sel;
    logic [LANES-1:0] best_sel;
    logic [LANES-1:0] last_ok;
    logic [PTR_W-1:0] sel_wr_ptr;
    logic             lane_in_range;
    logic             push_ok;
    logic             drop;
    logic             ready_all;
    logic             any_head;
    logic             complete;
    logic             clear;
    logic             out_load;
    logic             cmp_take;

    // Lanes at or above the effective count are treated as finished.
    always_comb begin
        if (act_cfg_reg == '0) begin
            eff_act = ACT_W'(1);
        end else if (int'(act_cfg_reg) > LANES) begin
            eff_act = ACT_W'(LANES);
        end else begin
            eff_act = ACT_W'(act_cfg_reg);
        end
    end

    always_comb begin
        sel_wr_ptr = '0;
        for (int i = 0; i < LANES; i++) begin
            active_vec[i]   = i < int'(eff_act);
            nonempty_vec[i] = count_reg[i] != '0;
            full_vec[i]     = count_reg[i] == CNT_W'(LANE_DEPTH);
            in_sel[i]       = i == int'(s_lane);
            best_sel[i]     = i == int'(best_idx_reg);
            last_ok[i]      = !active_vec[i] || (finished_reg[i] &&
                              (count_reg[i] == (best_sel[i] ? CNT_W'(1) : CNT_W'(0))));
            if (in_sel[i]) begin
                sel_wr_ptr = sel_wr_ptr | wr_ptr_reg[i];
            end
        end
    end

    assign lane_in_range = int'(s_lane) < int'(eff_act);
    assign push_ok       = s_has_value && lane_in_range && !(|(in_sel & finished_reg))
                           && !(|(in_sel & full_vec));
    assign drop          = s_has_value && !push_ok;

    assign ready_all = &(~active_vec | nonempty_vec | finished_reg);
    assign any_head  = |(active_vec & nonempty_vec);
    assign complete  = &(~active_vec | (finished_reg & ~nonempty_vec));

    assign status.pending       = ready_all && any_head && (n_reg < N_W'(kwm_pkg::RESULT_CAP));
    assign status.scan_last     = ACT_W'(issue_idx_reg) == (eff_act - ACT_W'(1));
    assign status.out_free      = !m_valid_reg || m_ready;
    assign status.last_pop      = &last_ok;
    assign status.finish_needed = (n_reg == '0) && (complete || err_reg);

    assign clear    = (cmd.pop && status.last_pop) || (cmd.emit_status && complete);
    assign out_load = cmd.pop || cmd.emit_status;
    assign cmp_take = cmp_valid_reg && nonempty_vec[cmp_idx_reg]
                      && (!best_any_reg || (rdata_reg < best_val_reg));

    assign waddr = ADDR_W'(s_lane) * ADDR_W'(LANE_DEPTH) + ADDR_W'(sel_wr_ptr);
    assign raddr = ADDR_W'(issue_idx_reg) * ADDR_W'(LANE_DEPTH)
                   + ADDR_W'(rd_ptr_reg[issue_idx_reg]);

    always_comb begin
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        count_next    = count_reg;
        finished_next = finished_reg;
        for (int i = 0; i < LANES; i++) begin
            if (cmd.push && in_sel[i]) begin
                if (push_ok) begin
                    wr_ptr_next[i] = ptr_inc(wr_ptr_reg[i]);
                    count_next[i]  = count_reg[i] + 1'b1;
                end
                if (s_lane_done && lane_in_range) begin
                    finished_next[i] = 1'b1;
                end
            end
            if (cmd.pop && best_sel[i]) begin
                rd_ptr_next[i] = ptr_inc(rd_ptr_reg[i]);
                count_next[i]  = count_reg[i] - 1'b1;
            end
            if (clear) begin
                rd_ptr_next[i] = '0;
                wr_ptr_next[i] = '0;
                count_next[i]  = '0;
            end
        end
        if (clear) begin
            finished_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_cfg_reg  <= kwm_pkg::ACT_RESET;
            finished_reg <= '0;
            for (int i = 0; i < LANES; i++) begin
                rd_ptr_reg[i] <= '0;
                wr_ptr_reg[i] <= '0;
                count_reg[i]  <= '0;
            end
        end else begin
            if (cfg_valid) begin
                act_cfg_reg <= cfg_active_lanes;
            end
            finished_reg <= finished_next;
            rd_ptr_reg   <= rd_ptr_next;
            wr_ptr_reg   <= wr_ptr_next;
            count_reg    <= count_next;
        end
    end

    // Lane queues share one memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.push && push_ok) begin
            mem[waddr] <= s_value;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_valid_reg <= 1'b0;
            best_any_reg  <= 1'b0;
            issue_idx_reg <= '0;
            err_reg       <= 1'b0;
            n_reg         <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            cmp_valid_reg <= cmd.scan_issue;
            if (cmd.scan_start) begin
                issue_idx_reg <= '0;
                best_any_reg  <= 1'b0;
            end else begin
                if (cmd.scan_issue) begin
                    issue_idx_reg <= issue_idx_reg + 1'b1;
                end
                if (cmp_take) begin
                    best_any_reg <= 1'b1;
                end
            end
            if (cmd.push) begin
                err_reg <= drop;
                n_reg   <= '0;
            end else if (out_load) begin
                err_reg <= 1'b0;
                n_reg   <= n_reg + 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg <= issue_idx_reg;
        if (cmp_take) begin
            best_val_reg <= rdata_reg;
            best_idx_reg <= cmp_idx_reg;
        end
        if (cmd.pop) begin
            m_value_reg     <= best_val_reg;
            m_valid_res_reg <= 1'b1;
            m_last_reg      <= status.last_pop;
            m_error_reg     <= err_reg;
        end else if (cmd.emit_status) begin
            m_value_reg     <= '0;
            m_valid_res_reg <= 1'b0;
            m_last_reg      <= complete;
            m_error_reg     <= err_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_merged_value = m_value_reg;
    assign m_valid_res    = m_valid_res_reg;
    assign m_last         = m_last_reg;
    assign m_error        = m_error_reg;

endmodule

@@ rtl/k_way_merge.sv @@
// Top level of the k-way merge block: controller, datapath and configuration port.
//
//  channel  | handshake             | words carried
//  ---------+-----------------------+---------------------------------------------------
//  input    | s_valid / s_ready     | s_lane, s_value, s_has_value, s_lane_done
//  result   | m_valid / m_ready     | m_merged_value, m_valid_res, m_last, m_error
//  config   | cfg_valid / cfg_ready | cfg_active_lanes
//
// One input word is taken at a time. For every element it releases, where A is
// the effective number of active lanes, the head scan reads the A lane heads,
// one lane head a cycle, from the shared queue memory through its single
// registered read port.
// Reset is synchronous and active low; the queue memory itself is not
// cleared, since per-lane counts and pointers guard every read of it.
// A stalled result channel holds the block in its emit state; the last result
// of a step may still wait in the output register while the next input word
// is accepted.
`timescale 1ns / 1ps

module k_way_merge #(
    parameter int LANES      = 4,
    parameter int LANE_DEPTH = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input words: one element and/or an end-of-lane mark for one lane.
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [kwm_pkg::LANE_W-1:0]         s_lane,
    input  logic signed [kwm_pkg::DATA_W-1:0]  s_value,
    input  logic                               s_has_value,
    input  logic                               s_lane_done,
    // Configuration: number of lanes in use.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [kwm_pkg::CFG_W-1:0]          cfg_active_lanes,
    // Result words: merged elements and status.
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [kwm_pkg::DATA_W-1:0]  m_merged_value,
    output logic                               m_valid_res,
    output logic                               m_last,
    output logic                               m_error
);

    kwm_pkg::kwm_cmd_t    cmd;
    kwm_pkg::kwm_status_t status;

    // The user must change the register only while the block is idle; the block
    // itself does not enforce it. A write is always taken at once.
    assign cfg_ready = 1'b1;

    // The controller sequences each step: enqueue, check whether every active
    // lane has a head or has ended, scan the heads, pop the smallest, and finally emit
    // a status-only word when a step ends with an error or completion but no
    // element.
    kwm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath owns the lane queues, the finished flags, the running
    // minimum of the scan and the output register. Ties keep the lower lane
    // because lanes are scanned in ascending order with a strict compare.
    kwm_datapath #(
        .LANES      (LANES),
        .LANE_DEPTH (LANE_DEPTH)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_lane           (s_lane),
        .s_value          (s_value),
        .s_has_value      (s_has_value),
        .s_lane_done      (s_lane_done),
        .cfg_valid        (cfg_valid),
        .cfg_active_lanes (cfg_active_lanes),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_merged_value   (m_merged_value),
        .m_valid_res      (m_valid_res),
        .m_last           (m_last),
        .m_error          (m_error)
    );

endmodule

@@ rtl/kwm_checker.sv @@
// Port-level checker of the k-way merge block and its bind.
`timescale 1ns / 1ps
`include "k_way_merge_assert.svh"

module kwm_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [kwm_pkg::DATA_W-1:0]  m_merged_value,
    input logic                               m_valid_res,
    input logic                               m_last,
    input logic                               m_error
);

    // A stalled result word stays valid and keeps its value and last flag.
    `KWM_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_merged_value) && $stable(m_last))

    // A word without an element carries zero.
    `KWM_ASSERT_SAME(a_empty_zero, m_valid && !m_valid_res, m_merged_value == '0)

    // A word without an element exists only to report completion or a drop.
    `KWM_ASSERT_SAME(a_empty_reason, m_valid && !m_valid_res, m_last || m_error)

    // Input words are handled one at a time.
    `KWM_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready)

endmodule

bind k_way_merge kwm_checker u_kwm_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_merged_value (m_merged_value),
    .m_valid_res    (m_valid_res),
    .m_last         (m_last),
    .m_error        (m_error)
);

@@ tb/k_way_merge_tb.sv @@
// Self-checking testbench for the k-way merge block: directed table, then random merges.
`timescale 1ns / 1ps

module k_way_merge_tb;

    import kwm_pkg::*;

    localparam int N_LANES      = 4;
    localparam int FIFO_DEPTH   = 16;
    localparam int RANDOM_WORDS = 450;
    // A word that releases nothing still passes through the block's check and finish states.
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 300;
    localparam int PRINT_CAP     = 100;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [LANE_W-1:0]        lane_t;
    typedef logic [CFG_W-1:0]         cfg_t;

    // One result word as the merge should produce it.
    typedef struct packed {
        data_t value;
        logic  has_elem;
        logic  last;
        logic  error;
    } merge_word_t;

    typedef enum int {ROW_WORD, ROW_CHECKED, ROW_CFG} row_kind_e;
    typedef enum int {NOISE_IDLE, NOISE_OUTSIDE, NOISE_LATE} noise_e;

    typedef struct {
        row_kind_e   kind;
        int          lane;
        data_t       value;
        bit          has;
        bit          done;
        merge_word_t want;
    } dir_row_t;

    logic  aclk = 1'b0;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    lane_t s_lane;
    data_t s_value;
    logic  s_has_value;
    logic  s_lane_done;
    logic  cfg_valid;
    logic  cfg_ready;
    cfg_t  cfg_active_lanes;
    logic  m_valid;
    logic  m_ready;
    data_t m_merged_value;
    logic  m_valid_res;
    logic  m_last;
    logic  m_error;

    // Shadow of the lane queues and the register, kept in step with accepted words.
    data_t queued [N_LANES][FIFO_DEPTH];
    int    rd_ptr [N_LANES];
    int    wr_ptr [N_LANES];
    int    fill   [N_LANES];
    bit    closed [N_LANES];
    cfg_t  active_reg;

    merge_word_t step_words[$];
    merge_word_t merge_expect_q[$];
    dir_row_t    dir_rows[$];

    int mismatches   = 0;
    int words_sent   = 0;
    int live_words   = 0;
    int results_seen = 0;
    int err_seen     = 0;
    int last_seen    = 0;
    int cfg_writes   = 0;
    int long_holds   = 0;
    int burst_left   = 0;
    bit quiet_sender = 1'b0;
    bit long_hold_req = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    k_way_merge #(
        .LANES      (N_LANES),
        .LANE_DEPTH (FIFO_DEPTH)
    ) uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_lane           (s_lane),
        .s_value          (s_value),
        .s_has_value      (s_has_value),
        .s_lane_done      (s_lane_done),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_active_lanes (cfg_active_lanes),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_merged_value   (m_merged_value),
        .m_valid_res      (m_valid_res),
        .m_last           (m_last),
        .m_error          (m_error)
    );

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP) begin
            $display("MISMATCH @%0t: %s", $time, what);
        end
        mismatches++;
    endtask

    function automatic int used_lanes();
        if (active_reg == '0) begin
            return 1;
        end
        if (int'(active_reg) > N_LANES) begin
            return N_LANES;
        end
        return int'(active_reg);
    endfunction

    function automatic void clear_lanes();
        for (int i = 0; i < N_LANES; i++) begin
            rd_ptr[i] = 0;
            wr_ptr[i] = 0;
            fill[i]   = 0;
            closed[i] = 1'b0;
        end
    endfunction

    // Applies one accepted word to the shadow state and leaves its results in step_words.
    function automatic void predict_merge(input int lane, input data_t val, input bit has,
                                          input bit done);
        int          act;
        int          n;
        int          best;
        bit          err;
        bit          ready;
        bit          found;
        bit          complete;
        data_t       best_val;
        merge_word_t w;
        step_words.delete();
        act = used_lanes();
        err = 1'b0;
        n   = 0;
        // The value is queued first, then the end mark, then merging runs.
        if (has) begin
            if (lane >= act || closed[lane] || fill[lane] >= FIFO_DEPTH) begin
                err = 1'b1;
            end else begin
                queued[lane][wr_ptr[lane]] = val;
                wr_ptr[lane] = (wr_ptr[lane] + 1) % FIFO_DEPTH;
                fill[lane]++;
            end
        end
        if (done && lane < act) begin
            closed[lane] = 1'b1;
        end
        while (n < RESULT_CAP) begin
            ready    = 1'b1;
            found    = 1'b0;
            best     = 0;
            best_val = '0;
            for (int i = 0; i < act; i++) begin
                if (fill[i] == 0) begin
                    if (!closed[i]) begin
                        ready = 1'b0;
                    end
                end else if (!found || queued[i][rd_ptr[i]] < best_val) begin
                    // Strict compare keeps the lowest lane on a tie.
                    found    = 1'b1;
                    best     = i;
                    best_val = queued[i][rd_ptr[i]];
                end
            end
            if (!ready || !found) begin
                break;
            end
            w.value    = best_val;
            w.has_elem = 1'b1;
            w.last     = 1'b0;
            w.error    = (n == 0) ? err : 1'b0;
            step_words.push_back(w);
            rd_ptr[best] = (rd_ptr[best] + 1) % FIFO_DEPTH;
            fill[best]--;
            n++;
        end
        complete = 1'b1;
        for (int i = 0; i < act; i++) begin
            if (!closed[i] || fill[i] != 0) begin
                complete = 1'b0;
            end
        end
        w = '0;
        if (complete) begin
            if (n > 0) begin
                step_words[n-1].last = 1'b1;
            end else begin
                w.last  = 1'b1;
                w.error = err;
                step_words.push_back(w);
            end
            clear_lanes();
        end else if (n == 0 && err) begin
            w.error = 1'b1;
            step_words.push_back(w);
        end
    endfunction

    // Offers one input word, waits for it to be taken and records what it should release.
    // A typed word, where given, stands in for the predicted results of this word.
    task automatic push_word(input int lane, input data_t val, input bit has, input bit done,
                             input bit typed = 1'b0, input merge_word_t typed_word = '0);
        int gap;
        if (burst_left == 0) begin
            gap        = quiet_sender ? 0 : $urandom_range(0, 5);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_lane      <= lane_t'(lane);
        s_value     <= val;
        s_has_value <= has;
        s_lane_done <= done;
        do @(posedge aclk); while (s_ready !== 1'b1);
        words_sent++;
        if (has || done) begin
            live_words++;
        end
        predict_merge(lane, val, has, done);
        if (typed) begin
            merge_expect_q.push_back(typed_word);
        end else begin
            foreach (step_words[k]) begin
                merge_expect_q.push_back(step_words[k]);
            end
        end
    endtask

    // Stops offering words until every expected result is out and the block has settled.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (merge_expect_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_active(input cfg_t v);
        wait_drained();
        @(negedge aclk);
        cfg_valid        <= 1'b1;
        cfg_active_lanes <= v;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        active_reg = v;
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Stray words: idle words, values for lanes out of use, values after a lane's end mark.
    task automatic push_noise(input int act, input bit shut[N_LANES]);
        int     l;
        int     late;
        noise_e kind;
        kind = noise_e'($urandom_range(0, 2));
        l    = $urandom_range(0, N_LANES - 1);
        late = -1;
        for (int i = 0; i < act; i++) begin
            if (shut[i]) begin
                late = i;
            end
        end
        case (kind)
            NOISE_OUTSIDE: begin
                if (act < N_LANES) begin
                    push_word($urandom_range(act, N_LANES - 1), $urandom,
                              bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)));
                end else begin
                    push_word(l, $urandom, 1'b0, 1'b0);
                end
            end
            NOISE_LATE: begin
                if (late >= 0) begin
                    push_word(late, $urandom, bit'($urandom_range(0, 3) != 0),
                              bit'($urandom_range(0, 1)));
                end else begin
                    push_word(l, $urandom, 1'b0, 1'b0);
                end
            end
            default: begin
                push_word(l, $urandom, 1'b0, 1'b0);
            end
        endcase
    endtask

    // One complete merge: mostly sorted streams with random content, interleaved across lanes,
    // each lane closed by an end mark. A flood run overfills one lane before the others
    // start, so its queue runs full.
    task automatic run_merge(input bit flood, input bit big);
        int act;
        int len;
        int fl;
        int l;
        int open_lanes;
        int sent [N_LANES];
        bit shut [N_LANES];
        int vals [N_LANES][$];
        int seq[$];
        bit narrow;
        bit dflag;
        act = used_lanes();
        fl  = -1;
        if (flood && act >= 2) begin
            fl = $urandom_range(0, act - 1);
        end
        for (int i = 0; i < N_LANES; i++) begin
            seq.delete();
            sent[i] = 0;
            shut[i] = 1'b0;
            if (i < act) begin
                narrow = ($urandom_range(0, 3) == 0);
                if (i == fl) begin
                    len = $urandom_range(16, 19);
                end else if (big) begin
                    len = $urandom_range(8, 12);
                end else begin
                    len = $urandom_range(0, 6);
                end
                // Narrow values make ties between lanes common.
                repeat (len) begin
                    seq.push_back(narrow ? int'($urandom_range(0, 16)) - 8 : int'($urandom));
                end
                if ($urandom_range(0, 9) != 0) begin
                    seq.sort();
                end
            end
            vals[i] = seq;
        end
        if (fl >= 0) begin
            while (sent[fl] < vals[fl].size()) begin
                push_word(fl, vals[fl][sent[fl]], 1'b1, 1'b0);
                sent[fl]++;
            end
        end
        open_lanes = act;
        while (open_lanes > 0) begin
            if ($urandom_range(0, 11) == 0) begin
                push_noise(act, shut);
            end
            do l = $urandom_range(0, act - 1); while (shut[l]);
            if (sent[l] < vals[l].size()) begin
                dflag = (sent[l] == vals[l].size() - 1) && ($urandom_range(0, 1) == 1);
                push_word(l, vals[l][sent[l]], 1'b1, dflag);
                sent[l]++;
            end else begin
                dflag = 1'b1;
                push_word(l, $urandom, 1'b0, 1'b1);
            end
            if (dflag) begin
                shut[l] = 1'b1;
                open_lanes--;
            end
        end
    endtask

    function automatic dir_row_t mk_row(input row_kind_e kind, input int lane, input data_t value,
                                        input bit has = 1'b0, input bit done = 1'b0,
                                        input data_t ev = '0, input bit evr = 1'b0,
                                        input bit el = 1'b0, input bit ee = 1'b0);
        dir_row_t r;
        r.kind          = kind;
        r.lane          = lane;
        r.value         = value;
        r.has           = has;
        r.done          = done;
        r.want.value    = ev;
        r.want.has_elem = evr;
        r.want.last     = el;
        r.want.error    = ee;
        return r;
    endfunction

    // Every result word is matched, in order, against the oldest expectation.
    always @(posedge aclk) begin : result_check
        merge_word_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            results_seen++;
            if (m_error === 1'b1) begin
                err_seen++;
            end
            if (m_last === 1'b1) begin
                last_seen++;
            end
            if (merge_expect_q.size() == 0) begin
                report_mismatch($sformatf("result word %0d with nothing expected (value %0d)",
                                          results_seen, m_merged_value));
            end else begin
                want = merge_expect_q.pop_front();
                if (m_merged_value !== want.value || m_valid_res !== want.has_elem ||
                        m_last !== want.last || m_error !== want.error) begin
                    report_mismatch($sformatf(
                        "result word %0d: got %0d/%b/%b/%b, expected %0d/%b/%b/%b",
                        results_seen, m_merged_value, m_valid_res, m_last, m_error,
                        want.value, want.has_elem, want.last, want.error));
                end
            end
        end
    end

    // Result side: a random 16-bit stall pattern, redrawn once played out, plus long hold-offs on request.
    initial begin : result_sink
        logic [15:0] stall_pat;
        int          pat_pos;
        int          hold_left;
        m_ready   = 1'b0;
        stall_pat = 16'hFFFF;
        pat_pos   = 0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                long_holds++;
                m_ready <= 1'b0;
            end else begin
                m_ready <= stall_pat[pat_pos];
                pat_pos++;
                if (pat_pos == 16) begin
                    pat_pos = 0;
                    case ($urandom_range(0, 3))
                        0: stall_pat = 16'hFFFF;
                        1: stall_pat = 16'($urandom);
                        2: stall_pat = 16'($urandom | $urandom);
                        default: stall_pat = 16'($urandom & $urandom) | 16'h0001;
                    endcase
                end
            end
        end
    end

    initial begin : stimulus
        int   merge_idx;
        bit   big;
        cfg_t v;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_lane           = '0;
        s_value          = '0;
        s_has_value      = 1'b0;
        s_lane_done      = 1'b0;
        cfg_valid        = 1'b0;
        cfg_active_lanes = '0;
        active_reg       = ACT_RESET;
        clear_lanes();

        // All four lanes in use after reset.
        dir_rows.push_back(mk_row(ROW_WORD, 0, 32'sh7FFF_FFFF, 1'b1, 1'b1));
        // A value for a lane that has already ended is dropped with an error word.
        dir_rows.push_back(mk_row(ROW_CHECKED, 0, 32'sd5, 1'b1, 1'b0, '0, 1'b0, 1'b0, 1'b1));
        dir_rows.push_back(mk_row(ROW_WORD, 1, 32'sh8000_0000, 1'b1, 1'b1));
        dir_rows.push_back(mk_row(ROW_WORD, 2, 32'shFFFF_FFFF, 1'b0, 1'b1));
        dir_rows.push_back(mk_row(ROW_WORD, 3, 32'sd0, 1'b1, 1'b0));
        // Repeated end mark, then a word that carries nothing at all.
        dir_rows.push_back(mk_row(ROW_WORD, 2, 32'sd0, 1'b0, 1'b1));
        dir_rows.push_back(mk_row(ROW_WORD, 3, 32'sd0, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(ROW_CHECKED, 3, 32'sd0, 1'b0, 1'b1,
                                  32'sh7FFF_FFFF, 1'b1, 1'b1, 1'b0));
        // Equal heads on every lane: the lowest lane goes first.
        dir_rows.push_back(mk_row(ROW_WORD, 1, 32'sd7, 1'b1, 1'b0));
        dir_rows.push_back(mk_row(ROW_WORD, 2, 32'sd7, 1'b1, 1'b0));
        dir_rows.push_back(mk_row(ROW_WORD, 3, 32'sd7, 1'b1, 1'b0));
        dir_rows.push_back(mk_row(ROW_WORD, 0, 32'sd7, 1'b1, 1'b0));
        dir_rows.push_back(mk_row(ROW_WORD, 0, 32'sd0, 1'b0, 1'b1));
        // A setting of zero means one lane; lanes 2 and 3 keep stale data that is ignored.
        dir_rows.push_back(mk_row(ROW_CFG, 0, 32'sd0));
        dir_rows.push_back(mk_row(ROW_CHECKED, 2, 32'shAAAA_AAAA, 1'b1, 1'b1,
                                  '0, 1'b0, 1'b1, 1'b1));
        dir_rows.push_back(mk_row(ROW_CHECKED, 0, 32'sd3, 1'b1, 1'b1,
                                  32'sd3, 1'b1, 1'b1, 1'b0));
        // A setting above the lane count means all lanes.
        dir_rows.push_back(mk_row(ROW_CFG, 0, 32'sd7));
        dir_rows.push_back(mk_row(ROW_WORD, 3, 32'sh5555_5555, 1'b1, 1'b0));
        dir_rows.push_back(mk_row(ROW_WORD, 0, -32'sd100, 1'b1, 1'b1));
        dir_rows.push_back(mk_row(ROW_WORD, 1, 32'sd0, 1'b0, 1'b1));
        dir_rows.push_back(mk_row(ROW_WORD, 2, -32'sd100, 1'b1, 1'b1));
        // The merge completes on a word that releases no element.
        dir_rows.push_back(mk_row(ROW_CHECKED, 3, 32'sd0, 1'b0, 1'b1, '0, 1'b0, 1'b1, 1'b0));
        dir_rows.push_back(mk_row(ROW_CFG, 0, 32'sd4));

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                write_active(cfg_t'(dir_rows[i].value));
            end else begin
                push_word(dir_rows[i].lane, dir_rows[i].value, dir_rows[i].has,
                          dir_rows[i].done, dir_rows[i].kind == ROW_CHECKED, dir_rows[i].want);
            end
        end

        live_words = 0;
        merge_idx  = 0;
        while (live_words < RANDOM_WORDS) begin
            big = (merge_idx == 4 || merge_idx == 17);
            if (big) begin
                // Long output stall during a large four-lane merge fills the block up.
                write_active(cfg_t'(N_LANES));
                long_hold_req = 1'b1;
            end else if (merge_idx % 3 == 0) begin
                case ($urandom_range(0, 9))
                    0: v = '0;
                    1: v = cfg_t'($urandom_range(5, 7));
                    default: v = cfg_t'($urandom_range(1, 4));
                endcase
                write_active(v);
            end else if (merge_idx == 10) begin
                wait_drained();
            end
            quiet_sender = (merge_idx % 5 == 2);
            run_merge(merge_idx % 7 == 5, big);
            merge_idx++;
        end

        wait_drained();
        $display("Covered %0d input words in %0d random merges, %0d register writes,",
                 words_sent, merge_idx, cfg_writes);
        $display("%0d result words checked (%0d errors, %0d merge ends), %0d long output stalls.",
                 results_seen, err_seen, last_seen, long_holds);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #1_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
